FILE: rtl/core/rcsde_pkg.sv
// Package for the RC stick dead zone and switch edge block.
// Holds widths, register codes, reset values and the shared struct types.
// No dependencies.
package rcsde_pkg;

   // Lane count and field widths
   localparam int NUM_STICKS = 4;
   localparam int RAW_W      = 16;
   localparam int STICK_W    = 16;
   localparam int LEVEL_W    = 10;
   localparam int MAG_W      = 9;
   localparam int DZ_W       = 9;
   localparam int GAIN_W     = 32;
   localparam int THR_W      = 11;
   localparam int PROD_W     = MAG_W + GAIN_W;
   localparam int SCALE_SH   = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // Stick arithmetic constants
   localparam logic signed [RAW_W:0]     STICK_CENTRE = 17'sd1500;
   localparam logic signed [RAW_W:0]     STICK_LIMIT  = 17'sd500;
   localparam logic [PROD_W-SCALE_SH-1:0] Q15_MAX     = 25'd32767;

   // Switch level constants
   localparam logic [RAW_W-1:0] SWITCH_BASE = 16'd1000;
   localparam logic [RAW_W-1:0] SWITCH_SPAN = 16'd1000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STICK_GAIN  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOVER_THR   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_THR = 4'd3;

   // Register reset values
   localparam logic [DZ_W-1:0]   DEAD_ZONE_RST   = 9'd25;
   localparam logic [GAIN_W-1:0] STICK_GAIN_RST  = 32'd4521018;
   localparam logic [THR_W-1:0]  HOVER_THR_RST   = 11'd1250;
   localparam logic [THR_W-1:0]  COMMAND_THR_RST = 11'd1750;

   typedef struct packed {
      logic [DZ_W-1:0]   dz_half;
      logic [GAIN_W-1:0] gain;
      logic [THR_W-1:0]  hover_thr;
      logic [THR_W-1:0]  command_thr;
   } cfg_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
   } stick_mag_type;

   typedef struct packed {
      logic lvl_hover;
      logic lvl_cmd;
      logic rise_hover;
      logic rise_cmd;
      logic fall_hover;
      logic fall_cmd;
   } gear_flags_type;

endpackage

FILE: rtl/core/rcsde_csr.sv
// Configuration registers: dead zone, stick gain and gear thresholds.
// Depends on rcsde_pkg.
module rcsde_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rcsde_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcsde_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rcsde_pkg::cfg_type                  cfg
);

   rcsde_pkg::cfg_type cfg_ff, cfg_in;

   // Writes are always accepted; ready is tied high
   assign csr_ready = 1'b1;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rcsde_pkg::CSR_DEAD_ZONE:   cfg_in.dz_half     = csr_wdata[rcsde_pkg::DZ_W-1:0];
            rcsde_pkg::CSR_STICK_GAIN:  cfg_in.gain        = csr_wdata[rcsde_pkg::GAIN_W-1:0];
            rcsde_pkg::CSR_HOVER_THR:   cfg_in.hover_thr   = csr_wdata[rcsde_pkg::THR_W-1:0];
            rcsde_pkg::CSR_COMMAND_THR: cfg_in.command_thr = csr_wdata[rcsde_pkg::THR_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dz_half     <= rcsde_pkg::DEAD_ZONE_RST;
         cfg_ff.gain        <= rcsde_pkg::STICK_GAIN_RST;
         cfg_ff.hover_thr   <= rcsde_pkg::HOVER_THR_RST;
         cfg_ff.command_thr <= rcsde_pkg::COMMAND_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/rcsde_stick_front.sv
// Stick front end: centre, clamp to the span and remove the dead zone.
// Produces the excess magnitude and sign for one stick. Depends on rcsde_pkg.
module rcsde_stick_front (
   input  logic [rcsde_pkg::RAW_W-1:0] raw,
   input  logic [rcsde_pkg::DZ_W-1:0]  dz_half,
   output rcsde_pkg::stick_mag_type    shaped
);

   localparam int D_W = 11;

   logic signed [rcsde_pkg::RAW_W:0] d_full;
   logic signed [D_W-1:0]            d;
   logic signed [D_W-1:0]            dz;
   logic signed [D_W-1:0]            excess;

   // Centre and clamp to +/- span
   always_comb begin
      d_full = $signed({1'b0, raw}) - rcsde_pkg::STICK_CENTRE;
      if (d_full > rcsde_pkg::STICK_LIMIT) begin
         d = rcsde_pkg::STICK_LIMIT[D_W-1:0];
      end else if (d_full < -rcsde_pkg::STICK_LIMIT) begin
         d = -rcsde_pkg::STICK_LIMIT[D_W-1:0];
      end else begin
         d = d_full[D_W-1:0];
      end
   end

   // Dead zone: keep only the part beyond the half-width
   always_comb begin
      dz         = $signed({2'b00, dz_half});
      excess     = '0;
      shaped.neg = 1'b0;
      if (d > dz) begin
         excess = d - dz;
      end else if (d < -dz) begin
         excess     = -d - dz;
         shaped.neg = 1'b1;
      end
      shaped.mag = excess[rcsde_pkg::MAG_W-1:0];
   end

endmodule

FILE: rtl/core/rcsde_stick_scale.sv
// Stick back end: gain multiply, Q1.15 saturation and sign restore.
// Depends on rcsde_pkg.
module rcsde_stick_scale (
   input  rcsde_pkg::stick_mag_type              shaped,
   input  logic [rcsde_pkg::GAIN_W-1:0]          gain,
   output logic signed [rcsde_pkg::STICK_W-1:0]  stick
);

   localparam int SH_W = rcsde_pkg::PROD_W - rcsde_pkg::SCALE_SH;

   logic [rcsde_pkg::PROD_W-1:0]  prod;
   logic [SH_W-1:0]               scaled;
   logic [rcsde_pkg::STICK_W-2:0] sat;

   // 9 x 32 multiply, drop 16 fraction bits, clip to full scale
   always_comb begin
      prod   = {{rcsde_pkg::GAIN_W{1'b0}}, shaped.mag} *
               {{rcsde_pkg::MAG_W{1'b0}}, gain};
      scaled = prod[rcsde_pkg::PROD_W-1:rcsde_pkg::SCALE_SH];
      if (scaled > rcsde_pkg::Q15_MAX) begin
         sat = rcsde_pkg::Q15_MAX[rcsde_pkg::STICK_W-2:0];
      end else begin
         sat = scaled[rcsde_pkg::STICK_W-2:0];
      end
      stick = shaped.neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
   end

endmodule

FILE: rtl/core/rcsde_gear.sv
// Gear switch tracker: classifies bottom/middle/top and flags edges
// against the previous frame's pulse. Depends on rcsde_pkg.
module rcsde_gear (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [rcsde_pkg::RAW_W-1:0]   gear_raw,
   input  logic [rcsde_pkg::THR_W-1:0]   hover_thr,
   input  logic [rcsde_pkg::THR_W-1:0]   command_thr,
   output rcsde_pkg::gear_flags_type     flags
);

   logic [rcsde_pkg::RAW_W-1:0] prev_gear_ff, prev_gear_in;
   logic                        seen_ff, seen_in;
   logic [rcsde_pkg::RAW_W-1:0] prev;
   logic [rcsde_pkg::RAW_W-1:0] hv;
   logic [rcsde_pkg::RAW_W-1:0] cm;
   logic                        g_mid, g_top;
   logic                        p_mid, p_low, p_top;

   // First frame compares against itself, so no edges
   always_comb begin
      hv    = {{(rcsde_pkg::RAW_W-rcsde_pkg::THR_W){1'b0}}, hover_thr};
      cm    = {{(rcsde_pkg::RAW_W-rcsde_pkg::THR_W){1'b0}}, command_thr};
      prev  = seen_ff ? prev_gear_ff : gear_raw;
      g_mid = (gear_raw > hv) && (gear_raw < cm);
      g_top = !(gear_raw < cm);
      p_mid = (prev > hv) && (prev < cm);
      p_low = !(prev > hv);
      p_top = !(prev < cm);
   end

   // Level and edge flags, rules checked in priority order
   always_comb begin
      flags = '0;
      if (g_mid) begin
         flags.lvl_hover = 1'b1;
         if (p_low) begin
            flags.rise_hover = 1'b1;
         end else if (p_top) begin
            flags.fall_cmd = 1'b1;
         end
      end else if (g_top) begin
         flags.lvl_hover = 1'b1;
         flags.lvl_cmd   = 1'b1;
         flags.rise_cmd  = p_mid || p_low;
      end else begin
         if (p_mid) begin
            flags.fall_hover = 1'b1;
         end else if (p_top) begin
            flags.fall_hover = 1'b1;
            flags.fall_cmd   = 1'b1;
         end
      end
   end

   // Previous pulse is updated on every accepted frame
   always_comb begin
      prev_gear_in = take ? gear_raw : prev_gear_ff;
      seen_in      = seen_ff || take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_gear_ff <= '0;
         seen_ff      <= 1'b0;
      end else begin
         prev_gear_ff <= prev_gear_in;
         seen_ff      <= seen_in;
      end
   end

   // With crossed thresholds a top pulse can also judge as low, so the
   // enter-command edge is left out here
   a_first_no_edge: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> !(flags.rise_hover || flags.fall_hover || flags.fall_cmd))
      else $error("gear edge flagged before any frame was seen");

   a_command_is_hover: assert property (@(posedge clock) disable iff (reset)
      flags.lvl_cmd |-> flags.lvl_hover)
      else $error("command level without hover level");

   a_take_sets_seen: assert property (@(posedge clock) disable iff (reset)
      take |=> (seen_ff && prev_gear_ff == $past(gear_raw)))
      else $error("gear history not captured on transfer");

endmodule

FILE: rtl/core/rc_stick_deadzone_and_switch_edges.sv
// RC frame conditioner top level: stick dead zone and gear switch edges; uses rcsde_pkg.
// Pipeline: an input register, then a result register after the gain multipliers
// (one 9x32 multiplier per stick), which drives rsp_valid.
// Throughput: one frame per cycle; the input stalls only while both registers
// hold a frame and the result is stalled.
// Reset: synchronous; clears valids and gear history, loads register defaults.
module rc_stick_deadzone_and_switch_edges (
   input  logic                                      clock,
   input  logic                                      reset,
   // input frame
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [rcsde_pkg::RAW_W-1:0]               req_stick_raw_0,
   input  logic [rcsde_pkg::RAW_W-1:0]               req_stick_raw_1,
   input  logic [rcsde_pkg::RAW_W-1:0]               req_stick_raw_2,
   input  logic [rcsde_pkg::RAW_W-1:0]               req_stick_raw_3,
   input  logic [rcsde_pkg::RAW_W-1:0]               req_mode_raw,
   input  logic [rcsde_pkg::RAW_W-1:0]               req_gear_raw,
   input  logic [rcsde_pkg::RAW_W-1:0]               req_reboot_raw,
   // result
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [rcsde_pkg::STICK_W-1:0]      rsp_stick_0,
   output logic signed [rcsde_pkg::STICK_W-1:0]      rsp_stick_1,
   output logic signed [rcsde_pkg::STICK_W-1:0]      rsp_stick_2,
   output logic signed [rcsde_pkg::STICK_W-1:0]      rsp_stick_3,
   output logic [rcsde_pkg::LEVEL_W-1:0]             rsp_mode_level,
   output logic [rcsde_pkg::LEVEL_W-1:0]             rsp_reboot_level,
   output logic                                      rsp_is_hover,
   output logic                                      rsp_is_command,
   output logic                                      rsp_enter_hover,
   output logic                                      rsp_enter_command,
   output logic                                      rsp_exit_hover,
   output logic                                      rsp_exit_command,
   // configuration writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [rcsde_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [rcsde_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   rcsde_pkg::cfg_type cfg;

   logic [rcsde_pkg::RAW_W-1:0]           stick_raw   [rcsde_pkg::NUM_STICKS];
   rcsde_pkg::stick_mag_type              stick_shape [rcsde_pkg::NUM_STICKS];
   logic signed [rcsde_pkg::STICK_W-1:0]  stick_out   [rcsde_pkg::NUM_STICKS];
   rcsde_pkg::gear_flags_type             gear_flags;

   // input stage
   logic                                  s1_vld_ff, s1_vld_in;
   rcsde_pkg::stick_mag_type              s1_stick_ff [rcsde_pkg::NUM_STICKS];
   logic [rcsde_pkg::LEVEL_W-1:0]         s1_mode_ff, s1_reboot_ff;
   rcsde_pkg::gear_flags_type             s1_flags_ff;

   // result stage
   logic                                  out_vld_ff, out_vld_in;
   logic signed [rcsde_pkg::STICK_W-1:0]  out_stick_ff [rcsde_pkg::NUM_STICKS];
   logic [rcsde_pkg::LEVEL_W-1:0]         out_mode_ff, out_reboot_ff;
   rcsde_pkg::gear_flags_type             out_flags_ff;

   logic                                  req_take;
   logic                                  out_load;
   logic                                  rsp_take;
   logic [rcsde_pkg::LEVEL_W-1:0]         mode_level, reboot_level;

   // Switch pulse to offset from base, clamped to the span
   function automatic logic [rcsde_pkg::LEVEL_W-1:0] switch_level(
      input logic [rcsde_pkg::RAW_W-1:0] raw
   );
      logic [rcsde_pkg::RAW_W-1:0] r;
      r = raw - rcsde_pkg::SWITCH_BASE;
      if (raw <= rcsde_pkg::SWITCH_BASE) begin
         return '0;
      end else if (r > rcsde_pkg::SWITCH_SPAN) begin
         return rcsde_pkg::SWITCH_SPAN[rcsde_pkg::LEVEL_W-1:0];
      end else begin
         return r[rcsde_pkg::LEVEL_W-1:0];
      end
   endfunction

   rcsde_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Pipeline control: result register loads when empty or being drained
   always_comb begin
      rsp_take   = out_vld_ff && !rsp_stall;
      out_load   = s1_vld_ff && (!out_vld_ff || !rsp_stall);
      req_stall  = s1_vld_ff && !out_load;
      req_take   = req_valid && !req_stall;
      s1_vld_in  = req_take || (s1_vld_ff && !out_load);
      out_vld_in = out_load || (out_vld_ff && !rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign stick_raw[0] = req_stick_raw_0;
   assign stick_raw[1] = req_stick_raw_1;
   assign stick_raw[2] = req_stick_raw_2;
   assign stick_raw[3] = req_stick_raw_3;

   // Stick lanes: dead zone ahead of the input register, gain after it
   for (genvar i = 0; i < rcsde_pkg::NUM_STICKS; i++) begin : g_lane
      rcsde_stick_front u_front (
         .raw     (stick_raw[i]),
         .dz_half (cfg.dz_half),
         .shaped  (stick_shape[i])
      );

      rcsde_stick_scale u_scale (
         .shaped (s1_stick_ff[i]),
         .gain   (cfg.gain),
         .stick  (stick_out[i])
      );
   end

   rcsde_gear u_gear (
      .clock       (clock),
      .reset       (reset),
      .take        (req_take),
      .gear_raw    (req_gear_raw),
      .hover_thr   (cfg.hover_thr),
      .command_thr (cfg.command_thr),
      .flags       (gear_flags)
   );

   assign mode_level   = switch_level(req_mode_raw);
   assign reboot_level = switch_level(req_reboot_raw);

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_stick_ff  <= stick_shape;
         s1_mode_ff   <= mode_level;
         s1_reboot_ff <= reboot_level;
         s1_flags_ff  <= gear_flags;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_stick_ff  <= stick_out;
         out_mode_ff   <= s1_mode_ff;
         out_reboot_ff <= s1_reboot_ff;
         out_flags_ff  <= s1_flags_ff;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_stick_0       = out_stick_ff[0];
   assign rsp_stick_1       = out_stick_ff[1];
   assign rsp_stick_2       = out_stick_ff[2];
   assign rsp_stick_3       = out_stick_ff[3];
   assign rsp_mode_level    = out_mode_ff;
   assign rsp_reboot_level  = out_reboot_ff;
   assign rsp_is_hover      = out_flags_ff.lvl_hover;
   assign rsp_is_command    = out_flags_ff.lvl_cmd;
   assign rsp_enter_hover   = out_flags_ff.rise_hover;
   assign rsp_enter_command = out_flags_ff.rise_cmd;
   assign rsp_exit_hover    = out_flags_ff.fall_hover;
   assign rsp_exit_command  = out_flags_ff.fall_cmd;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_vld_ff && out_vld_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_load) |=> s1_vld_ff)
      else $error("input stage dropped a frame");

   a_stick_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_stick_0 != 16'sh8000 && rsp_stick_1 != 16'sh8000 &&
                     rsp_stick_2 != 16'sh8000 && rsp_stick_3 != 16'sh8000))
      else $error("stick output outside symmetric Q1.15 range");

endmodule
